FILE: design/bounded_ordered_list_assert.svh
// Assertion macros for bounded_ordered_list
`ifndef BOUNDED_ORDERED_LIST_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ASSERT_SVH

`ifndef SYNTHESIS

`define BOL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bounded_ordered_list: check failed");

`define BOL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bounded_ordered_list: check failed");

`else

`define BOL_ASSERT_NOW(label, ante, cons)

`define BOL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: design/bol_pkg.sv
package bol_pkg;

	localparam int WORD_W = 32;
	localparam int POS_W  = 8;
	localparam int CNT_W  = 5;
	localparam int REQ_W  = 3;
	localparam int STAT_W = 3;

	typedef enum logic [REQ_W-1:0] {
		REQ_INS_HEAD = 3'd0,
		REQ_INS_POS  = 3'd1,
		REQ_INS_TAIL = 3'd2,
		REQ_RM_HEAD  = 3'd3,
		REQ_RM_VALUE = 3'd4,
		REQ_RM_TAIL  = 3'd5,
		REQ_READ_ALL = 3'd6,
		REQ_NONE     = 3'd7
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 3'd0,
		ST_EMPTY     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL      = 3'd3,
		ST_BAD_POS   = 3'd4
	} status_t;

	// per-cycle command broadcast to every cell
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_INS  = 2'd1,
		CELL_SHL  = 2'd2,
		CELL_ROT  = 2'd3
	} cell_op_t;

endpackage

FILE: design/bol_cell.sv
module bol_cell
	import bol_pkg::*;
#(
	parameter int INDEX      = 0,
	parameter int IDX_W      = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [IDX_W-1:0]      idx,
	input  logic [DATA_WIDTH-1:0] new_word,
	input  logic [DATA_WIDTH-1:0] head_word,
	input  logic [DATA_WIDTH-1:0] left_word,
	input  logic [DATA_WIDTH-1:0] right_word,
	output logic [DATA_WIDTH-1:0] word
);

	localparam logic [IDX_W-1:0] HERE = IDX_W'(INDEX);

	logic [DATA_WIDTH-1:0] word_q;
	logic [DATA_WIDTH-1:0] word_d;

	always_comb begin
		word_d = word_q;
		unique case (op)
			CELL_HOLD: word_d = word_q;
			CELL_INS: begin
				if (HERE > idx) begin
					word_d = left_word;
				end else if (HERE == idx) begin
					word_d = new_word;
				end
			end
			CELL_SHL: begin
				if (HERE >= idx) begin
					word_d = right_word;
				end
			end
			CELL_ROT: begin
				// wrap point takes the head word, the rest move toward the head
				word_d = (HERE == idx) ? head_word : right_word;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign word = word_q;

endmodule

FILE: design/bol_chain.sv
module bol_chain
	import bol_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int IDX_W      = 4,
	parameter int DATA_WIDTH = 32
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [IDX_W-1:0]      idx,
	input  logic [DATA_WIDTH-1:0] new_word,
	output logic [DATA_WIDTH-1:0] head_word
);

	logic [DATA_WIDTH-1:0] words [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		bol_cell #(
			.INDEX      (i),
			.IDX_W      (IDX_W),
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk        (clk),
			.op         (op),
			.idx        (idx),
			.new_word   (new_word),
			.head_word  (words[0]),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i])
		);
	end

	assign head_word = words[0];

endmodule

FILE: design/bounded_ordered_list.sv
// Inserts, remove head and every error but not-found: the result is registered from the execute
// state that reads the command register; busy drops as it appears, so a new request can start.
// Remove value, remove tail and readout rotate a non-empty list once through the cell chain:
// busy until the rotation ends, one readout word per cycle, last marking the final word.
// arst_n empties the list (count 0); stored words are not cleared. No stall on results.
`include "bounded_ordered_list_assert.svh"

module bounded_ordered_list
	import bol_pkg::*;
#(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [REQ_W-1:0]         req_type,
	input  logic signed [WORD_W-1:0] value,
	input  logic [POS_W-1:0]         position,
	output logic                     valid,
	output logic [STAT_W-1:0]        status,
	output logic signed [WORD_W-1:0] entry,
	output logic                     last,
	output logic [CNT_W-1:0]         count
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);
	localparam int EXT_W  = (DATA_WIDTH > WORD_W) ? DATA_WIDTH : WORD_W;
	localparam int CMP_W  = POS_W + 1;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_ROT
	} state_t;

	function automatic logic [WORD_W-1:0] to_entry(input logic [DATA_WIDTH-1:0] w);
		logic signed [EXT_W-1:0] x;
		x = EXT_W'(signed'(w));
		return x[WORD_W-1:0];
	endfunction

	state_t                state_q, state_nxt;
	req_t                  cmd_q;
	logic [DATA_WIDTH-1:0] word_q;
	logic [POS_W-1:0]      pos_q;
	logic [FILL_W-1:0]     fill_q, fill_nxt;
	logic [FILL_W-1:0]     rem_q, rem_nxt;
	logic                  found_q, found_nxt;
	logic [DATA_WIDTH-1:0] removed_q, removed_nxt;

	logic                  valid_q, res_valid;
	status_t               status_q, res_status;
	logic [WORD_W-1:0]     entry_q, res_entry;
	logic                  last_q, res_last;
	logic [CNT_W-1:0]      count_q;

	logic [EXT_W-1:0]      value_ext;
	logic [DATA_WIDTH-1:0] value_word;
	logic [DATA_WIDTH-1:0] head_word;
	cell_op_t              op;
	logic [IDX_W-1:0]      idx;
	logic [IDX_W-1:0]      ins_idx;
	logic                  full, empty, pos_bad, head_match, rot_last, drop;

	assign value_ext  = EXT_W'(value);
	assign value_word = value_ext[DATA_WIDTH-1:0];

	assign full       = (fill_q == FILL_W'(DEPTH));
	assign empty      = (fill_q == '0);
	assign pos_bad    = ({1'b0, pos_q} > (CMP_W'(fill_q) + CMP_W'(1)));
	assign head_match = (head_word == word_q);
	assign rot_last   = (rem_q == FILL_W'(1));
	assign drop       = ((cmd_q == REQ_RM_VALUE) && !found_q && head_match) ||
	                    ((cmd_q == REQ_RM_TAIL) && rot_last);

	always_comb begin
		ins_idx = '0;
		priority if (cmd_q == REQ_INS_TAIL) begin
			ins_idx = IDX_W'(fill_q);
		end else if ((cmd_q == REQ_INS_POS) && (pos_q > POS_W'(1))) begin
			ins_idx = IDX_W'(pos_q - POS_W'(1));
		end
	end

	always_comb begin
		state_nxt   = state_q;
		fill_nxt    = fill_q;
		rem_nxt     = rem_q;
		found_nxt   = found_q;
		removed_nxt = removed_q;
		op          = CELL_HOLD;
		idx         = '0;
		res_valid   = 1'b0;
		res_status  = ST_OK;
		res_entry   = '0;
		res_last    = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt = S_IDLE;
				unique case (cmd_q)
					REQ_INS_HEAD, REQ_INS_POS, REQ_INS_TAIL: begin
						res_valid = 1'b1;
						if (full) begin
							res_status = ST_FULL;
						end else if ((cmd_q == REQ_INS_POS) && pos_bad) begin
							res_status = ST_BAD_POS;
						end else begin
							op       = CELL_INS;
							idx      = ins_idx;
							fill_nxt = fill_q + FILL_W'(1);
						end
					end
					REQ_RM_HEAD: begin
						res_valid = 1'b1;
						if (empty) begin
							res_status = ST_EMPTY;
						end else begin
							op        = CELL_SHL;
							fill_nxt  = fill_q - FILL_W'(1);
							res_entry = to_entry(head_word);
						end
					end
					REQ_RM_VALUE, REQ_RM_TAIL, REQ_READ_ALL: begin
						if (empty) begin
							res_valid  = 1'b1;
							res_status = ST_EMPTY;
						end else begin
							state_nxt = S_ROT;
							rem_nxt   = fill_q;
							found_nxt = 1'b0;
						end
					end
					REQ_NONE: begin
					end
				endcase
			end
			S_ROT: begin
				rem_nxt = rem_q - FILL_W'(1);
				if (drop) begin
					op          = CELL_SHL;
					fill_nxt    = fill_q - FILL_W'(1);
					found_nxt   = 1'b1;
					removed_nxt = head_word;
				end else begin
					op  = CELL_ROT;
					idx = IDX_W'(fill_q - FILL_W'(1));
				end
				if (cmd_q == REQ_READ_ALL) begin
					res_valid = 1'b1;
					res_entry = to_entry(head_word);
					res_last  = rot_last;
				end
				if (rot_last) begin
					state_nxt = S_IDLE;
					if (cmd_q != REQ_READ_ALL) begin
						res_valid = 1'b1;
						if (drop) begin
							res_entry = to_entry(head_word);
						end else if (found_q) begin
							res_entry = to_entry(removed_q);
						end else begin
							res_status = ST_NOT_FOUND;
						end
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cmd_q     <= REQ_NONE;
			word_q    <= '0;
			pos_q     <= '0;
			fill_q    <= '0;
			rem_q     <= '0;
			found_q   <= 1'b0;
			removed_q <= '0;
			valid_q   <= 1'b0;
			status_q  <= ST_OK;
			entry_q   <= '0;
			last_q    <= 1'b0;
			count_q   <= '0;
		end else begin
			state_q   <= state_nxt;
			fill_q    <= fill_nxt;
			rem_q     <= rem_nxt;
			found_q   <= found_nxt;
			removed_q <= removed_nxt;
			valid_q   <= res_valid;
			status_q  <= res_status;
			entry_q   <= res_entry;
			last_q    <= res_last;
			count_q   <= CNT_W'(fill_nxt);
			if ((state_q == S_IDLE) && start) begin
				cmd_q  <= req_t'(req_type);
				word_q <= value_word;
				pos_q  <= position;
			end
		end
	end

	bol_chain #(
		.DEPTH      (DEPTH),
		.IDX_W      (IDX_W),
		.DATA_WIDTH (DATA_WIDTH)
	) u_chain (
		.clk       (clk),
		.op        (op),
		.idx       (idx),
		.new_word  (word_q),
		.head_word (head_word)
	);

	assign busy   = (state_q != S_IDLE);
	assign valid  = valid_q;
	assign status = status_q;
	assign entry  = entry_q;
	assign last   = last_q;
	assign count  = count_q;

	`BOL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
	`BOL_ASSERT_NOW(a_word_after_busy, valid, $past(busy))
	`BOL_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(DEPTH))
	`BOL_ASSERT_NOW(a_more_follows, valid && !last, busy)

endmodule

FILE: sim/testbench.sv
module testbench;
	import bol_pkg::*;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int N_RANDOM   = 190;
	localparam int QUIET_FROM = 160;

	typedef struct {
		logic [STAT_W-1:0]        status;
		logic signed [WORD_W-1:0] entry;
		logic                     last;
		logic [CNT_W-1:0]         count;
	} list_result_t;

	typedef struct {
		req_t                     req;
		logic signed [WORD_W-1:0] value;
		logic [POS_W-1:0]         position;
		bit                       typed;
		status_t                  status;
		logic signed [WORD_W-1:0] entry;
		logic [CNT_W-1:0]         count;
	} stim_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic [REQ_W-1:0]         req_type = REQ_NONE;
	logic signed [WORD_W-1:0] value = '0;
	logic [POS_W-1:0]         position = '0;
	logic                     busy;
	logic                     valid;
	logic [STAT_W-1:0]        status;
	logic signed [WORD_W-1:0] entry;
	logic                     last;
	logic [CNT_W-1:0]         count;

	logic signed [WORD_W-1:0] list_words[$];
	list_result_t             due_results[$];
	int                       errors = 0;
	int                       n_requests = 0;
	int                       n_checked = 0;
	int                       n_full = 0;
	int                       n_bad_pos = 0;

	// every directed row gives at most one result except the readouts
	stim_row_t directed[20] = '{
		'{REQ_READ_ALL, 32'sh0,        8'd0,   1'b1, ST_EMPTY,     32'sh0,        5'd0},
		'{REQ_RM_HEAD,  32'sh0,        8'd0,   1'b1, ST_EMPTY,     32'sh0,        5'd0},
		'{REQ_RM_VALUE, 32'sh0,        8'd0,   1'b1, ST_EMPTY,     32'sh0,        5'd0},
		'{REQ_RM_TAIL,  32'sh0,        8'd0,   1'b1, ST_EMPTY,     32'sh0,        5'd0},
		'{REQ_INS_POS,  32'sh1,        8'd2,   1'b1, ST_BAD_POS,   32'sh0,        5'd0},
		'{REQ_INS_POS,  32'sh7fffffff, 8'd0,   1'b1, ST_OK,        32'sh0,        5'd1},
		'{REQ_RM_VALUE, 32'sh7fffffff, 8'd0,   1'b1, ST_OK,        32'sh7fffffff, 5'd0},
		'{REQ_INS_HEAD, 32'sh80000000, 8'd0,   1'b1, ST_OK,        32'sh0,        5'd1},
		'{REQ_INS_TAIL, 32'sh0,        8'd0,   1'b1, ST_OK,        32'sh0,        5'd2},
		'{REQ_INS_POS,  32'shffffffff, 8'd1,   1'b1, ST_OK,        32'sh0,        5'd3},
		'{REQ_INS_POS,  32'sh55555555, 8'd4,   1'b1, ST_OK,        32'sh0,        5'd4},
		'{REQ_INS_POS,  32'shaaaaaaaa, 8'd255, 1'b1, ST_BAD_POS,   32'sh0,        5'd4},
		'{REQ_INS_POS,  32'shaaaaaaaa, 8'd3,   1'b1, ST_OK,        32'sh0,        5'd5},
		'{REQ_READ_ALL, 32'sh0,        8'd0,   1'b0, ST_OK,        32'sh0,        5'd0},
		'{REQ_RM_VALUE, 32'sd12345,    8'd0,   1'b1, ST_NOT_FOUND, 32'sh0,        5'd5},
		'{REQ_NONE,     32'shffffffff, 8'd255, 1'b0, ST_OK,        32'sh0,        5'd0},
		'{REQ_RM_VALUE, 32'sh0,        8'd0,   1'b0, ST_OK,        32'sh0,        5'd0},
		'{REQ_RM_HEAD,  32'sh0,        8'd0,   1'b0, ST_OK,        32'sh0,        5'd0},
		'{REQ_RM_TAIL,  32'sh0,        8'd0,   1'b0, ST_OK,        32'sh0,        5'd0},
		'{REQ_READ_ALL, 32'sh0,        8'd0,   1'b0, ST_OK,        32'sh0,        5'd0}
	};

	bounded_ordered_list #(
		.DEPTH(DEPTH),
		.DATA_WIDTH(DATA_WIDTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req_type(req_type),
		.value(value),
		.position(position),
		.valid(valid),
		.status(status),
		.entry(entry),
		.last(last),
		.count(count)
	);

	always #4 clk = ~clk;

	task automatic add_result(input status_t st, input logic signed [WORD_W-1:0] w,
			input logic lst);
		list_result_t r;
		r.status = st;
		r.entry  = w;
		r.last   = lst;
		r.count  = CNT_W'(list_words.size());
		due_results.push_back(r);
		if (st == ST_FULL)
			n_full++;
		if (st == ST_BAD_POS)
			n_bad_pos++;
	endtask

	// applies one request to the list copy and queues the words it produces
	task automatic apply_to_list(input logic [REQ_W-1:0] req,
			input logic signed [WORD_W-1:0] v, input logic [POS_W-1:0] p);
		int idx;
		bit hit;
		logic signed [WORD_W-1:0] w;
		hit = 1'b0;
		case (req_t'(req))
			REQ_INS_HEAD, REQ_INS_POS, REQ_INS_TAIL: begin
				if (list_words.size() >= DEPTH) begin
					add_result(ST_FULL, '0, 1'b1);
				end else if (req == REQ_INS_POS && int'(p) > list_words.size() + 1) begin
					add_result(ST_BAD_POS, '0, 1'b1);
				end else begin
					if (req == REQ_INS_HEAD)
						idx = 0;
					else if (req == REQ_INS_TAIL)
						idx = list_words.size();
					else
						idx = (p <= 1) ? 0 : int'(p) - 1;
					list_words.insert(idx, v);
					add_result(ST_OK, '0, 1'b1);
				end
			end
			REQ_RM_HEAD, REQ_RM_TAIL: begin
				if (list_words.size() == 0) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					w = (req == REQ_RM_HEAD) ? list_words.pop_front() : list_words.pop_back();
					add_result(ST_OK, w, 1'b1);
				end
			end
			REQ_RM_VALUE: begin
				if (list_words.size() == 0) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (idx = 0; idx < list_words.size() && !hit; idx++) begin
						if (list_words[idx] == v) begin
							hit = 1'b1;
							list_words.delete(idx);
							add_result(ST_OK, v, 1'b1);
						end
					end
					if (!hit)
						add_result(ST_NOT_FOUND, '0, 1'b1);
				end
			end
			REQ_READ_ALL: begin
				if (list_words.size() == 0) begin
					add_result(ST_EMPTY, '0, 1'b1);
				end else begin
					for (idx = 0; idx < list_words.size(); idx++)
						add_result(ST_OK, list_words[idx], idx == list_words.size() - 1);
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input logic [REQ_W-1:0] req, input logic signed [WORD_W-1:0] v,
			input logic [POS_W-1:0] p);
		start    <= 1'b1;
		req_type <= req;
		value    <= v;
		position <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (req != REQ_NONE)
			n_requests++;
	endtask

	task automatic idle_burst(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0)
			@(posedge clk);
	endtask

	// phase 0 grows the list, phase 1 keeps it level, phase 2 shrinks it
	function automatic logic [REQ_W-1:0] pick_req(input int phase);
		int r;
		int ins_pct;
		r = $urandom_range(99);
		ins_pct = (phase == 0) ? 75 : (phase == 1) ? 45 : 20;
		if (r < 3)
			return REQ_NONE;
		if (r < 13)
			return REQ_READ_ALL;
		if (r < 13 + ins_pct) begin
			case ($urandom_range(2))
				0: return REQ_INS_HEAD;
				1: return REQ_INS_POS;
				default: return REQ_INS_TAIL;
			endcase
		end
		case ($urandom_range(2))
			0: return REQ_RM_HEAD;
			1: return REQ_RM_VALUE;
			default: return REQ_RM_TAIL;
		endcase
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 30 && list_words.size() != 0)
			return list_words[$urandom_range(list_words.size() - 1)];
		if (r < 45) begin
			case ($urandom_range(3))
				0: return 32'sh80000000;
				1: return 32'sh7fffffff;
				2: return 32'sh0;
				default: return 32'shffffffff;
			endcase
		end
		if (r < 70)
			return $signed(32'($urandom_range(7))) - 32'sd3;
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return POS_W'($urandom_range(list_words.size() + 1));
		if (r < 85)
			return POS_W'($urandom_range(255, list_words.size() + 2));
		return POS_W'($urandom_range(255));
	endfunction

	task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		list_result_t exp_r;
		if (arst_n && valid) begin
			if (due_results.size() == 0) begin
				$error("unexpected word: status %0d entry %0h last %0b count %0d",
					status, entry, last, count);
				errors++;
			end else begin
				exp_r = due_results.pop_front();
				compare_field("status", WORD_W'(exp_r.status), WORD_W'(status));
				compare_field("entry", exp_r.entry, entry);
				compare_field("last", WORD_W'(exp_r.last), WORD_W'(last));
				compare_field("count", WORD_W'(exp_r.count), WORD_W'(count));
				n_checked++;
			end
		end
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int n;
		logic [REQ_W-1:0] rq;
		list_result_t tr;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if ($urandom_range(3) == 0)
				idle_burst($urandom_range(12, 1));
			send_word(directed[i].req, directed[i].value, directed[i].position);
			n = due_results.size();
			apply_to_list(directed[i].req, directed[i].value, directed[i].position);
			if (directed[i].typed) begin
				while (due_results.size() > n)
					void'(due_results.pop_back());
				tr.status = directed[i].status;
				tr.entry  = directed[i].entry;
				tr.last   = 1'b1;
				tr.count  = directed[i].count;
				due_results.push_back(tr);
			end
		end
		drain_results();

		for (int i = 0; i < N_RANDOM; i++) begin
			if (i == N_RANDOM / 2)
				drain_results();
			// no gaps in a middle stretch and at the end
			if (i < QUIET_FROM && !(i >= 60 && i < 90) && $urandom_range(2) == 0)
				idle_burst($urandom_range(12, 1));
			rq = pick_req((i / 35) % 3);
			send_word(rq, pick_value(), pick_position());
			apply_to_list(rq, value, position);
		end

		drain_results();
		repeat (DEPTH + 8) @(posedge clk);
		$display("Covered %0d requests, %0d result words checked,", n_requests, n_checked);
		$display("inserts refused as full %0d times, bad positions %0d times.",
			n_full, n_bad_pos);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
